// ----- hw/rtl/msbp_pkg.sv -----
// ----------------------------------------------------------------------------
// msbp_pkg
// Shared types and constants for the MSB-first bit field packer.
// ----------------------------------------------------------------------------
package msbp_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 6;
    localparam int OPCODE_BITS = 2;
    localparam int FREE_BITS_W = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [OPCODE_BITS-1:0] OP_WRITE  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_FLUSH  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_FLUSH,
        CMD_APPEND
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [VALUE_BITS-1:0]  value;
        logic [COUNT_BITS-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

// ----- hw/rtl/msbp_front.sv -----
// ----------------------------------------------------------------------------
// msbp_front
// Accepts items, saturates the bit count and classifies them into commands.
// Items with no effect (unused opcode, zero-length write) are dropped here.
// ----------------------------------------------------------------------------
module msbp_front #(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [msbp_pkg::OPCODE_BITS-1:0]  opcode,
    input  logic [msbp_pkg::VALUE_BITS-1:0]   data_value,
    input  logic [msbp_pkg::COUNT_BITS-1:0]   bit_count,
    input  msbp_pkg::q_status_t               q_status,
    output logic                              push,
    output msbp_pkg::cmd_t                    push_cmd
);

    localparam int CW = msbp_pkg::COUNT_BITS + 1;

    logic                            accept;
    logic                            keep;
    logic [msbp_pkg::COUNT_BITS-1:0] count_sat;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    always_comb
    begin
        if ({1'b0, bit_count} > CW'(MAX_FIELD_BITS))
            count_sat = msbp_pkg::COUNT_BITS'(MAX_FIELD_BITS);
        else
            count_sat = bit_count;
    end

    always_comb
    begin
        push_cmd.value = data_value;
        push_cmd.count = count_sat;
        push_cmd.kind  = msbp_pkg::CMD_WRITE;
        keep           = 1'b0;
        case (opcode)
            msbp_pkg::OP_WRITE:
            begin
                push_cmd.kind = msbp_pkg::CMD_WRITE;
                keep          = (count_sat != '0);
            end
            msbp_pkg::OP_FLUSH:
            begin
                push_cmd.kind = msbp_pkg::CMD_FLUSH;
                keep          = 1'b1;
            end
            msbp_pkg::OP_APPEND:
            begin
                push_cmd.kind = msbp_pkg::CMD_APPEND;
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

endmodule

// ----- hw/rtl/msbp_queue.sv -----
// ----------------------------------------------------------------------------
// msbp_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module msbp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  msbp_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output msbp_pkg::cmd_t       head,
    output msbp_pkg::q_status_t  status
);

    msbp_pkg::cmd_t                  entry_reg [msbp_pkg::QDEPTH];
    logic [msbp_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [msbp_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [msbp_pkg::QCNT_W-1:0]     count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign status.full      = (count_reg == msbp_pkg::QCNT_W'(msbp_pkg::QDEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head             = entry_reg[rd_ptr_reg];
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/msbp_back.sv -----
// ----------------------------------------------------------------------------
// msbp_back
// Executes commands: packs field bits into the pending byte one chunk per
// cycle (up to the next byte boundary) while the output is not stalled,
// flushes, appends, and drives the registered output.
// ----------------------------------------------------------------------------
module msbp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msbp_pkg::cmd_t                    head,
    input  msbp_pkg::q_status_t               q_status,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [msbp_pkg::BYTE_BITS-1:0]    out_byte,
    output logic                              last
);

    localparam int BB = msbp_pkg::BYTE_BITS;
    localparam int FW = msbp_pkg::FREE_BITS_W;
    localparam int CB = msbp_pkg::COUNT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_FLUSH,
        ST_APPEND
    } state_t;

    state_t                           state_reg,   state_next;
    logic [msbp_pkg::VALUE_BITS-1:0]  value_reg,   value_next;
    logic [CB-1:0]                    rem_reg,     rem_next;
    logic [BB-1:0]                    pending_reg, pending_next;
    logic [FW-1:0]                    free_reg,    free_next;
    logic                             out_valid_reg, out_valid_next;
    logic [BB-1:0]                    out_byte_reg,  out_byte_next;
    logic                             last_reg,      last_next;

    logic                             adv;
    logic                             has_pending;
    logic [FW-1:0]                    take;
    logic [CB-1:0]                    rem_after;
    logic [FW-1:0]                    free_after;
    logic [BB-1:0]                    chunk;
    logic [BB-1:0]                    merged;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last        = last_reg;
    assign adv         = !out_valid_reg || !out_stall;
    assign has_pending = (free_reg != FW'(BB));
    assign pop         = (state_reg == ST_IDLE) && q_status.not_empty;

    always_comb
    begin
        if (rem_reg < {{(CB-FW){1'b0}}, free_reg})
            take = rem_reg[FW-1:0];
        else
            take = free_reg;
        rem_after  = rem_reg - {{(CB-FW){1'b0}}, take};
        free_after = free_reg - take;
        chunk      = BB'(value_reg >> rem_after) & ~({BB{1'b1}} << take);
        merged     = pending_reg | (chunk << free_after);
    end

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        rem_next       = rem_reg;
        pending_next   = pending_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    value_next = head.value;
                    rem_next   = head.count;
                    case (head.kind)
                        msbp_pkg::CMD_WRITE:  state_next = ST_WRITE;
                        msbp_pkg::CMD_FLUSH:  state_next = ST_FLUSH;
                        msbp_pkg::CMD_APPEND: state_next = ST_APPEND;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                if (adv)
                begin
                    rem_next = rem_after;
                    if (free_after == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = merged;
                        last_next      = (rem_after < CB'(BB));
                        pending_next   = '0;
                        free_next      = FW'(BB);
                    end
                    else
                    begin
                        pending_next = merged;
                        free_next    = free_after;
                    end
                    if (rem_after == '0)
                        state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (adv)
                begin
                    if (has_pending)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = pending_reg;
                        last_next      = 1'b1;
                        pending_next   = '0;
                        free_next      = FW'(BB);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_APPEND:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    if (has_pending)
                    begin
                        out_byte_next = pending_reg;
                        last_next     = 1'b0;
                        pending_next  = '0;
                        free_next     = FW'(BB);
                    end
                    else
                    begin
                        out_byte_next = value_reg[BB-1:0];
                        last_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            value_reg     <= '0;
            rem_reg       <= '0;
            pending_reg   <= '0;
            free_reg      <= FW'(BB);
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            value_reg     <= value_next;
            rem_reg       <= rem_next;
            pending_reg   <= pending_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            last_reg      <= last_next;
        end
    end

endmodule

// ----- hw/rtl/msb_first_bit_field_packer_top.sv -----
// A result byte passes through the command queue, the back part's command
// registers and the output register before it shows at out_valid. The back
// part takes one command at a time from the queue while idle; it packs writes
// one chunk per cycle, up to each byte boundary, while the output is not stalled.
// Input is taken while the 2-entry command queue has room.
// Reset clears the pending byte (bit position back to bit 7), queue and output.
// ----------------------------------------------------------------------------
// msb_first_bit_field_packer_top
// Packs variable-width bit fields MSB first into a byte stream.
// ----------------------------------------------------------------------------
module msb_first_bit_field_packer_top #(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [msbp_pkg::OPCODE_BITS-1:0]  opcode,
    input  logic [msbp_pkg::VALUE_BITS-1:0]   data_value,
    input  logic [msbp_pkg::COUNT_BITS-1:0]   bit_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [msbp_pkg::BYTE_BITS-1:0]    out_byte,
    output logic                              last
);

    msbp_pkg::q_status_t q_status;
    msbp_pkg::cmd_t      push_cmd;
    msbp_pkg::cmd_t      head;
    logic                push;
    logic                pop;

    msbp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .data_value (data_value),
        .bit_count  (bit_count),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    msbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    msbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// ----- hw/rtl/msbp_checker.sv -----
// ----------------------------------------------------------------------------
// msbp_checker
// Port-level checks for the bit field packer, bound to the top level.
// ----------------------------------------------------------------------------
module msbp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [msbp_pkg::BYTE_BITS-1:0]    out_byte,
    input  logic                              last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled output item changed");

    // a non-final byte is followed at once by the next byte of the same item
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a multi-byte item");

    a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    a_rst_in: assert property (@(posedge clk) $rose(rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind msb_first_bit_field_packer_top msbp_checker u_msbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

// ----- test/msb_first_bit_field_packer_top_test.sv -----
// ----------------------------------------------------------------------------
// msb_first_bit_field_packer_top_test
// Drives write, flush, append and unused-opcode items into the packer, first
// from a directed table and then at random, and checks every emitted byte and
// its last flag against the table's bytes or an in-bench prediction, with random
// idling on the input and output side but for the last third of random items.
// ----------------------------------------------------------------------------
module msb_first_bit_field_packer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int MAX_FIELD_BITS = 32;
    localparam int RANDOM_ITEMS   = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 16;

    localparam logic [msbp_pkg::OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [msbp_pkg::BYTE_BITS-1:0] value;
        logic                           last;
    } stream_byte_t;

    typedef struct packed {
        logic [msbp_pkg::OPCODE_BITS-1:0] op;
        logic [msbp_pkg::VALUE_BITS-1:0]  value;
        logic [msbp_pkg::COUNT_BITS-1:0]  count;
        logic                             typed;
        logic [2:0]                       n_bytes;
        logic [31:0]                      bytes;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [msbp_pkg::OPCODE_BITS-1:0] opcode;
    logic [msbp_pkg::VALUE_BITS-1:0]  data_value;
    logic [msbp_pkg::COUNT_BITS-1:0]  bit_count;
    logic                             out_valid;
    logic                             out_stall;
    logic [msbp_pkg::BYTE_BITS-1:0]   out_byte;
    logic                             last;

    logic [msbp_pkg::BYTE_BITS-1:0]   pend_byte;
    logic [msbp_pkg::FREE_BITS_W-1:0] pend_free;
    stream_byte_t                     new_bytes[$];
    stream_byte_t                     expected_bytes[$];

    int send_idle_pct;
    int recv_idle_pct;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    // typed rows hold their bytes first to last from bit 31 down
    stim_row_t dir_rows [0:23] = '{
        '{msbp_pkg::OP_WRITE,  32'h0000_00FF, 6'd8,  1'b1, 3'd1, 32'hFF00_0000},
        '{msbp_pkg::OP_WRITE,  32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 32'h0},
        '{msbp_pkg::OP_FLUSH,  32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'hFFFF_FFFF, 6'd32, 1'b1, 3'd4, 32'hFFFF_FFFF},
        '{msbp_pkg::OP_WRITE,  32'h0000_0000, 6'd32, 1'b1, 3'd4, 32'h0000_0000},
        '{msbp_pkg::OP_WRITE,  32'h0000_0001, 6'd1,  1'b1, 3'd0, 32'h0},
        '{msbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h8000_0000},
        '{msbp_pkg::OP_APPEND, 32'h0000_00A5, 6'd0,  1'b1, 3'd1, 32'hA500_0000},
        '{msbp_pkg::OP_WRITE,  32'h0000_0005, 6'd3,  1'b1, 3'd0, 32'h0},
        '{msbp_pkg::OP_APPEND, 32'hFFFF_FF3C, 6'd63, 1'b1, 3'd2, 32'hA03C_0000},
        '{msbp_pkg::OP_WRITE,  32'hFFFF_FFFF, 6'd63, 1'b1, 3'd4, 32'hFFFF_FFFF},
        '{msbp_pkg::OP_WRITE,  32'h1234_5678, 6'd33, 1'b1, 3'd4, 32'h1234_5678},
        '{OP_UNUSED,           32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'h0000_007F, 6'd7,  1'b1, 3'd0, 32'h0},
        '{OP_UNUSED,           32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'hFFFF_FFFF, 6'd32, 1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'hDEAD_BEEF, 6'd13, 1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'h8000_0000, 6'd32, 1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'h0000_0002, 6'd2,  1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_APPEND, 32'hFFFF_FF00, 6'd40, 1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'h01FF_FFFF, 6'd25, 1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_WRITE,  32'h0000_0003, 6'd2,  1'b0, 3'd0, 32'h0},
        '{msbp_pkg::OP_FLUSH,  32'hFFFF_FFFF, 6'd32, 1'b0, 3'd0, 32'h0}
    };

    msb_first_bit_field_packer_top #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .data_value (data_value),
        .bit_count  (bit_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // bytes one item adds to the packed stream; updates the pending byte
    function automatic void predict_packing(
        input logic [msbp_pkg::OPCODE_BITS-1:0] op,
        input logic [msbp_pkg::VALUE_BITS-1:0]  val,
        input logic [msbp_pkg::COUNT_BITS-1:0]  cnt
    );
        int           n_bits;
        int           pos;
        stream_byte_t sb;
        new_bytes.delete();
        sb.last = 1'b0;
        if (op == msbp_pkg::OP_WRITE)
        begin
            n_bits = (cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(cnt);
            for (pos = n_bits - 1; pos >= 0; pos--)
            begin
                pend_free = pend_free - 1'b1;
                if (pos < msbp_pkg::VALUE_BITS && val[pos])
                    pend_byte[pend_free[2:0]] = 1'b1;
                if (pend_free == 0)
                begin
                    sb.value = pend_byte;
                    new_bytes.push_back(sb);
                    pend_byte = '0;
                    pend_free = msbp_pkg::FREE_BITS_W'(msbp_pkg::BYTE_BITS);
                end
            end
        end
        else if (op == msbp_pkg::OP_FLUSH || op == msbp_pkg::OP_APPEND)
        begin
            if (pend_free < msbp_pkg::BYTE_BITS)
            begin
                sb.value = pend_byte;
                new_bytes.push_back(sb);
                pend_byte = '0;
                pend_free = msbp_pkg::FREE_BITS_W'(msbp_pkg::BYTE_BITS);
            end
            if (op == msbp_pkg::OP_APPEND)
            begin
                sb.value = val[7:0];
                new_bytes.push_back(sb);
            end
        end
        if (new_bytes.size() > 0)
        begin
            sb = new_bytes.pop_back();
            sb.last = 1'b1;
            new_bytes.push_back(sb);
        end
    endfunction

    // called and returns at a falling edge
    task automatic send_item(
        input logic [msbp_pkg::OPCODE_BITS-1:0] op,
        input logic [msbp_pkg::VALUE_BITS-1:0]  val,
        input logic [msbp_pkg::COUNT_BITS-1:0]  cnt,
        input logic                             typed,
        input int                               n_typed,
        input logic [31:0]                      typed_bytes
    );
        int           k;
        stream_byte_t sb;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        data_value <= val;
        bit_count  <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_packing(op, val, cnt);
        if (typed)
        begin
            for (k = 0; k < n_typed; k++)
            begin
                sb.value = typed_bytes[31 - 8 * k -: 8];
                sb.last  = (k == n_typed - 1);
                expected_bytes.push_back(sb);
            end
        end
        else
        begin
            while (new_bytes.size() > 0)
                expected_bytes.push_back(new_bytes.pop_front());
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_output
        stream_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: expected none, actual %02h", out_byte);
                err_cnt++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    $error("out_byte: expected %02h, actual %02h", want.value, out_byte);
                    err_cnt++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL msb_first_bit_field_packer_top");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                               r;
        int                               n_sent;
        int                               pick;
        logic [msbp_pkg::OPCODE_BITS-1:0] op;
        logic [msbp_pkg::VALUE_BITS-1:0]  val;
        logic [msbp_pkg::COUNT_BITS-1:0]  cnt;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = msbp_pkg::OP_WRITE;
        data_value    = '0;
        bit_count     = '0;
        out_stall     = 1'b0;
        pend_byte     = '0;
        pend_free     = msbp_pkg::FREE_BITS_W'(msbp_pkg::BYTE_BITS);
        send_idle_pct = 17;
        recv_idle_pct = 47;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < $size(dir_rows); r++)
            send_item(dir_rows[r].op, dir_rows[r].value, dir_rows[r].count,
                      dir_rows[r].typed, int'(dir_rows[r].n_bytes), dir_rows[r].bytes);

        // hold off until the stream has drained
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);

        n_sent = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            if (n_sent == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 17;
            end
            else if (n_sent == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 62)
                op = msbp_pkg::OP_WRITE;
            else if (pick < 78)
                op = msbp_pkg::OP_FLUSH;
            else if (pick < 94)
                op = msbp_pkg::OP_APPEND;
            else
                op = OP_UNUSED;
            pick = $urandom_range(9);
            if (pick == 0)
                val = '0;
            else if (pick == 1)
                val = '1;
            else
                val = $urandom;
            pick = $urandom_range(19);
            if (pick == 0)
                cnt = '0;
            else if (pick == 1)
                cnt = msbp_pkg::COUNT_BITS'($urandom_range(63, 33));
            else if (pick < 5)
                cnt = msbp_pkg::COUNT_BITS'(32);
            else
                cnt = msbp_pkg::COUNT_BITS'($urandom_range(31, 1));
            send_item(op, val, cnt, 1'b0, 0, 32'h0);
            if (op != OP_UNUSED)
                n_sent++;
        end

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_cnt == 0)
            $display("PASS msb_first_bit_field_packer_top");
        else
            $display("FAIL msb_first_bit_field_packer_top");
        $finish;
    end

endmodule
